// ===== rtl/kcl_pkg.sv =====
// Shared types and constants for the keypad code lock controller.
// No dependencies; every other file imports this package.
`default_nettype none

package kcl_pkg;

    // Default sizes handed to the top-level parameters
    localparam int CODE_LENGTH_DEF = 4;
    localparam int TIMER_BITS_DEF  = 20;

    // Fixed field and register widths
    localparam int KEY_W    = 4;
    localparam int EVENT_W  = 4;
    localparam int DIGITS_W = 3;
    localparam int FAIL_W   = 4;
    localparam int TICKS_W  = 20;
    localparam int CFG_W    = 20;

    typedef logic [KEY_W-1:0]   t_key;
    typedef logic [FAIL_W-1:0]  t_fail;
    typedef logic [TICKS_W-1:0] t_ticks;

    // Command codes
    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Keys with a menu meaning
    localparam t_key KEY_A = 4'd10;
    localparam t_key KEY_B = 4'd11;
    localparam t_key KEY_C = 4'd12;

    // Configuration register indexes
    localparam logic CFG_MAX_ATTEMPTS  = 1'b0;
    localparam logic CFG_LOCKOUT_TICKS = 1'b1;

    // Configuration reset values
    localparam t_fail  MAX_ATTEMPTS_RST  = 4'd3;
    localparam t_ticks LOCKOUT_TICKS_RST = 20'd30000;

    // Fail count saturation point
    localparam t_fail FAIL_MAX = 4'd15;

    typedef enum logic [2:0] {
        MODE_CLOSED  = 3'd0,
        MODE_UNLOCK  = 3'd1,
        MODE_CURRENT = 3'd2,
        MODE_NEW     = 3'd3,
        MODE_OPEN    = 3'd4,
        MODE_LOCKOUT = 3'd5
    } t_mode;

    typedef enum logic [EVENT_W-1:0] {
        EV_IGNORED  = 4'd0,
        EV_ENTER    = 4'd1,
        EV_CURRENT  = 4'd2,
        EV_DIGIT    = 4'd3,
        EV_GRANTED  = 4'd4,
        EV_WRONG    = 4'd5,
        EV_NEWCODE  = 4'd6,
        EV_CHANGED  = 4'd7,
        EV_CLOSING  = 4'd8,
        EV_LOCKED   = 4'd9,
        EV_UNLOCKED = 4'd10
    } t_event;

    // One input word
    typedef struct packed {
        logic command;
        t_key key_code;
    } t_item;

    // One result word
    typedef struct packed {
        t_event              event_res;
        logic                door_open;
        logic [DIGITS_W-1:0] digits_entered;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/kcl_in_reg.sv =====
// Input register stage of the keypad code lock controller.
// Depends on kcl_pkg for the input word type.
`default_nettype none

module kcl_in_reg import kcl_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_valid,
    output logic  o_stall,
    input  t_item i_item,
    input  wire   i_down_ready,
    output logic  o_fire,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;
    logic  accept;

    // Hold the word while the core cannot take it
    assign o_stall = r_valid && !i_down_ready;
    assign accept  = i_valid && !o_stall;
    assign o_fire  = r_valid && i_down_ready;
    assign o_item  = r_item;

    // Advance the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_fire) begin
            r_valid <= 1'b0;
        end
    end

    // Capture the payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/kcl_core.sv =====
// Lock state, stored code, fail count and lockout timer, with the
// single-pass next-state and result logic. Depends on kcl_pkg.
`default_nettype none

module kcl_core import kcl_pkg::*; #(
    parameter int CODE_LENGTH = CODE_LENGTH_DEF,
    parameter int TIMER_BITS  = TIMER_BITS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire              i_cfg_index,
    input  wire [CFG_W-1:0]  i_cfg_data,
    input  wire              i_fire,
    input  t_item            i_item,
    output t_result          o_result
);

    localparam int CW = $clog2(CODE_LENGTH + 1);
    localparam int IW = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

    // Configuration registers
    t_fail  r_max_attempts;
    t_ticks r_lockout_ticks;

    // Lock state
    t_mode                 r_mode,  n_mode;
    logic [CW-1:0]         r_count, n_count;
    t_fail                 r_fail,  n_fail;
    logic [TIMER_BITS-1:0] r_timer, n_timer;
    t_key                  r_buf   [CODE_LENGTH];
    t_key                  r_code  [CODE_LENGTH];
    t_key                  n_code  [CODE_LENGTH];
    t_key                  entry_new [CODE_LENGTH];
    logic                  is_last;
    logic                  match;
    logic                  in_entry;
    t_event                event_res;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_attempts  <= MAX_ATTEMPTS_RST;
            r_lockout_ticks <= LOCKOUT_TICKS_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_MAX_ATTEMPTS) begin
                r_max_attempts <= i_cfg_data[FAIL_W-1:0];
            end else begin
                r_lockout_ticks <= i_cfg_data[TICKS_W-1:0];
            end
        end
    end

    // Entry with the current key dropped into its slot
    always_comb begin
        for (int i = 0; i < CODE_LENGTH; i++) begin
            entry_new[i] = (IW'(i) == r_count[IW-1:0]) ? i_item.key_code : r_buf[i];
        end
    end

    // Compare the completed entry with the stored code
    always_comb begin
        match = 1'b1;
        for (int i = 0; i < CODE_LENGTH; i++) begin
            if (entry_new[i] != r_code[i]) begin
                match = 1'b0;
            end
        end
    end

    assign is_last  = (r_count == CW'(CODE_LENGTH - 1));
    assign in_entry = (r_mode == MODE_UNLOCK) || (r_mode == MODE_CURRENT)
                   || (r_mode == MODE_NEW);

    // Next state
    always_comb begin
        n_mode  = r_mode;
        n_count = r_count;
        n_fail  = r_fail;
        n_timer = r_timer;
        n_code  = r_code;
        if (i_item.command == CMD_TICK) begin
            if (r_mode == MODE_LOCKOUT) begin
                if (r_timer <= TIMER_BITS'(1)) begin
                    n_timer = '0;
                    n_fail  = '0;
                    n_mode  = MODE_CLOSED;
                end else begin
                    n_timer = r_timer - TIMER_BITS'(1);
                end
            end
        end else begin
            case (r_mode)
                MODE_CLOSED: begin
                    if (i_item.key_code == KEY_A) begin
                        if (r_fail >= r_max_attempts) begin
                            n_mode  = MODE_LOCKOUT;
                            n_timer = TIMER_BITS'(r_lockout_ticks);
                        end else begin
                            n_mode  = MODE_UNLOCK;
                            n_count = '0;
                        end
                    end else if (i_item.key_code == KEY_B) begin
                        n_mode  = MODE_CURRENT;
                        n_count = '0;
                    end
                end
                MODE_OPEN: begin
                    if (i_item.key_code == KEY_C) begin
                        n_mode = MODE_CLOSED;
                    end
                end
                MODE_UNLOCK, MODE_CURRENT, MODE_NEW: begin
                    if (!is_last) begin
                        n_count = r_count + CW'(1);
                    end else begin
                        n_count = '0;
                        n_mode  = MODE_CLOSED;
                        if (r_mode == MODE_UNLOCK) begin
                            if (match) begin
                                n_mode = MODE_OPEN;
                            end else if (r_fail != FAIL_MAX) begin
                                n_fail = r_fail + FAIL_W'(1);
                            end
                        end else if (r_mode == MODE_CURRENT) begin
                            if (match) begin
                                n_mode = MODE_NEW;
                            end
                        end else begin
                            n_code = entry_new;
                        end
                    end
                end
                default: begin
                    n_mode = r_mode;
                end
            endcase
        end
    end

    // Result event
    always_comb begin
        event_res = EV_IGNORED;
        if (i_item.command == CMD_TICK) begin
            if (r_mode == MODE_LOCKOUT && r_timer <= TIMER_BITS'(1)) begin
                event_res = EV_UNLOCKED;
            end
        end else begin
            case (r_mode)
                MODE_CLOSED: begin
                    if (i_item.key_code == KEY_A) begin
                        event_res = (r_fail >= r_max_attempts) ? EV_LOCKED : EV_ENTER;
                    end else if (i_item.key_code == KEY_B) begin
                        event_res = EV_CURRENT;
                    end
                end
                MODE_OPEN: begin
                    if (i_item.key_code == KEY_C) begin
                        event_res = EV_CLOSING;
                    end
                end
                MODE_UNLOCK: begin
                    if (!is_last) begin
                        event_res = EV_DIGIT;
                    end else begin
                        event_res = match ? EV_GRANTED : EV_WRONG;
                    end
                end
                MODE_CURRENT: begin
                    if (!is_last) begin
                        event_res = EV_DIGIT;
                    end else begin
                        event_res = match ? EV_NEWCODE : EV_WRONG;
                    end
                end
                MODE_NEW: begin
                    event_res = is_last ? EV_CHANGED : EV_DIGIT;
                end
                default: begin
                    event_res = EV_IGNORED;
                end
            endcase
        end
    end

    assign o_result.event_res      = event_res;
    assign o_result.door_open      = (n_mode == MODE_OPEN);
    assign o_result.digits_entered = DIGITS_W'(n_count);

    // Advance the lock state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_CLOSED;
            r_count <= '0;
            r_fail  <= '0;
            r_timer <= '0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_count <= n_count;
            r_fail  <= n_fail;
            r_timer <= n_timer;
        end
    end

    // Collect entry keys
    always_ff @(posedge i_clk) begin
        if (i_fire && in_entry && i_item.command == CMD_KEY) begin
            r_buf <= entry_new;
        end
    end

    // Stored code, reset to keys 1, 2, 3, ...
    for (genvar g = 0; g < CODE_LENGTH; g++) begin : g_code
        localparam t_key CODE_RST = KEY_W'((g + 1) % 10);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_code[g] <= CODE_RST;
            end else if (i_fire) begin
                r_code[g] <= n_code[g];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/kcl_out_reg.sv =====
// Result register stage of the keypad code lock controller.
// Depends on kcl_pkg for the result word type.
`default_nettype none

module kcl_out_reg import kcl_pkg::*; (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_load,
    input  t_result i_result,
    output logic    o_ready,
    output logic    o_valid,
    input  wire     i_stall,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // Take a new word when empty or when the held one leaves this cycle
    assign o_ready  = !r_valid || !i_stall;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Hold the payload while stalled
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/keypad_code_lock_controller.sv =====
// Top level of the keypad code lock controller: input register, lock core,
// result register. Depends on kcl_pkg, kcl_in_reg, kcl_core, kcl_out_reg.
//
//   channel   direction  handshake                 payload
//   input     in         i_in_valid / o_in_stall   i_command, i_key_code
//   result    out        o_out_valid / i_out_stall o_event_res, o_door_open,
//                                                  o_digits_entered
//   config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// One word per cycle sustained while the result side does not stall. A word
// taken sits in the input register; the single-pass core loads its result into
// the result register, from which the result can leave. Reset is synchronous
// and active low; the stored code returns to 1,2,3,4 and the configuration to
// its defaults. A stall on the result side holds the result register and backs
// up into the input register.
`default_nettype none

module keypad_code_lock_controller import kcl_pkg::*; #(
    parameter int CODE_LENGTH = CODE_LENGTH_DEF,
    parameter int TIMER_BITS  = TIMER_BITS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire                i_cfg_index,
    input  wire [CFG_W-1:0]    i_cfg_data,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire                i_command,
    input  wire [KEY_W-1:0]    i_key_code,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic [EVENT_W-1:0] o_event_res,
    output logic               o_door_open,
    output logic [DIGITS_W-1:0] o_digits_entered
);

    t_item   in_item;
    t_item   core_item;
    t_result core_result;
    t_result out_result;
    logic    fire;
    logic    out_ready;

    assign in_item.command  = i_command;
    assign in_item.key_code = i_key_code;

    kcl_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_item       (in_item),
        .i_down_ready (out_ready),
        .o_fire       (fire),
        .o_item       (core_item)
    );

    kcl_core #(
        .CODE_LENGTH (CODE_LENGTH),
        .TIMER_BITS  (TIMER_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (fire),
        .i_item      (core_item),
        .o_result    (core_result)
    );

    kcl_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire),
        .i_result (core_result),
        .o_ready  (out_ready),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (out_result)
    );

    assign o_event_res      = out_result.event_res;
    assign o_door_open      = out_result.door_open;
    assign o_digits_entered = out_result.digits_entered;

endmodule

`default_nettype wire

// ===== dv/tb_keypad_code_lock_controller.sv =====
// Self-checking testbench for keypad_code_lock_controller: directed and random
// key/tick words under varied idling, checked against an in-bench lock model.
// Depends on kcl_pkg and the keypad_code_lock_controller RTL.
`default_nettype none

module tb_keypad_code_lock_controller import kcl_pkg::*;;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_WORDS  = 95;
    localparam int MAX_PRINTS   = 100;

    // Lock model with its own state, configuration and pending results
    class code_lock_checker;
        t_fail                     max_attempts;
        t_ticks                    lockout_ticks;
        t_mode                     mode;
        int                        entry_count;
        t_key                      entry_buf [CODE_LENGTH_DEF];
        t_key                      stored_code [CODE_LENGTH_DEF];
        t_fail                     fail_count;
        logic [TIMER_BITS_DEF-1:0] lockout_timer;
        t_result                   pending_results [$];
        int                        errors;

        function new();
            max_attempts  = MAX_ATTEMPTS_RST;
            lockout_ticks = LOCKOUT_TICKS_RST;
            mode          = MODE_CLOSED;
            entry_count   = 0;
            fail_count    = '0;
            lockout_timer = '0;
            errors        = 0;
            for (int i = 0; i < CODE_LENGTH_DEF; i++) begin
                entry_buf[i]   = '0;
                stored_code[i] = t_key'((i + 1) % 10);
            end
        endfunction

        function void set_reg(logic idx, logic [CFG_W-1:0] data);
            if (idx == CFG_MAX_ATTEMPTS) begin
                max_attempts = data[FAIL_W-1:0];
            end else begin
                lockout_ticks = data[TICKS_W-1:0];
            end
        endfunction

        // Collect one key of a code entry; compare once the entry is full
        function t_event take_digit(t_key key);
            logic same;
            entry_buf[entry_count] = key;
            entry_count++;
            if (entry_count < CODE_LENGTH_DEF) begin
                return EV_DIGIT;
            end
            entry_count = 0;
            same = 1'b1;
            for (int i = 0; i < CODE_LENGTH_DEF; i++) begin
                if (entry_buf[i] != stored_code[i]) begin
                    same = 1'b0;
                end
            end
            case (mode)
                MODE_UNLOCK: begin
                    if (same) begin
                        mode = MODE_OPEN;
                        return EV_GRANTED;
                    end
                    if (fail_count < FAIL_MAX) begin
                        fail_count++;
                    end
                    mode = MODE_CLOSED;
                    return EV_WRONG;
                end
                MODE_CURRENT: begin
                    if (same) begin
                        mode = MODE_NEW;
                        return EV_NEWCODE;
                    end
                    mode = MODE_CLOSED;
                    return EV_WRONG;
                end
                default: begin
                    for (int i = 0; i < CODE_LENGTH_DEF; i++) begin
                        stored_code[i] = entry_buf[i];
                    end
                    mode = MODE_CLOSED;
                    return EV_CHANGED;
                end
            endcase
        endfunction

        // Advance the lock by one word and return the result it produces
        function t_result advance_lock(logic cmd, t_key key);
            t_result r;
            t_event  ev;
            ev = EV_IGNORED;
            if (cmd == CMD_TICK) begin
                if (mode == MODE_LOCKOUT) begin
                    if (lockout_timer <= 1) begin
                        lockout_timer = '0;
                        fail_count    = '0;
                        mode          = MODE_CLOSED;
                        ev            = EV_UNLOCKED;
                    end else begin
                        lockout_timer--;
                    end
                end
            end else begin
                case (mode)
                    MODE_CLOSED: begin
                        if (key == KEY_A) begin
                            if (fail_count >= max_attempts) begin
                                mode          = MODE_LOCKOUT;
                                lockout_timer = lockout_ticks;
                                ev            = EV_LOCKED;
                            end else begin
                                mode        = MODE_UNLOCK;
                                entry_count = 0;
                                ev          = EV_ENTER;
                            end
                        end else if (key == KEY_B) begin
                            mode        = MODE_CURRENT;
                            entry_count = 0;
                            ev          = EV_CURRENT;
                        end
                    end
                    MODE_OPEN: begin
                        if (key == KEY_C) begin
                            mode = MODE_CLOSED;
                            ev   = EV_CLOSING;
                        end
                    end
                    MODE_UNLOCK, MODE_CURRENT, MODE_NEW: begin
                        ev = take_digit(key);
                    end
                    default: begin
                        ev = EV_IGNORED;
                    end
                endcase
            end
            r.event_res      = ev;
            r.door_open      = (mode == MODE_OPEN);
            r.digits_entered = DIGITS_W'(entry_count);
            return r;
        endfunction

        function void note_word(logic cmd, t_key key);
            pending_results.push_back(advance_lock(cmd, key));
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        task report_mismatch(string what);
            if (errors < MAX_PRINTS) begin
                $display("MISMATCH: %s", what);
            end
            errors++;
        endtask

        // Compare one result word with the oldest expectation
        task check_word(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected, event %0d",
                                          got.event_res));
                return;
            end
            want = pending_results.pop_front();
            if (got.event_res != want.event_res) begin
                report_mismatch($sformatf("event_res got %0d want %0d",
                                          got.event_res, want.event_res));
            end
            if (got.door_open != want.door_open) begin
                report_mismatch($sformatf("door_open got %0d want %0d",
                                          got.door_open, want.door_open));
            end
            if (got.digits_entered != want.digits_entered) begin
                report_mismatch($sformatf("digits_entered got %0d want %0d",
                                          got.digits_entered, want.digits_entered));
            end
        endtask
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic                i_cfg_index;
    logic [CFG_W-1:0]    i_cfg_data;
    logic                i_in_valid;
    logic                o_in_stall;
    logic                i_command;
    logic [KEY_W-1:0]    i_key_code;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [EVENT_W-1:0]  o_event_res;
    logic                o_door_open;
    logic [DIGITS_W-1:0] o_digits_entered;

    code_lock_checker sb;
    int               idle_pct;
    int               stall_pct;
    int               hold_left;
    int               cycles;
    logic             aim_good;

    keypad_code_lock_controller DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_key_code       (i_key_code),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_event_res      (o_event_res),
        .o_door_open      (o_door_open),
        .o_digits_entered (o_digits_entered)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Count cycles and give up at the limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Note accepted input words and check accepted result words
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                sb.note_word(i_command, i_key_code);
            end
            if (o_out_valid && !i_out_stall) begin
                got.event_res      = t_event'(o_event_res);
                got.door_open      = o_door_open;
                got.digits_entered = o_digits_entered;
                sb.check_word(got);
            end
        end
    end

    // Drive the result-side stall: a long hold when asked, else random
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall = 1'b0;
        end else if (hold_left > 0) begin
            i_out_stall = 1'b1;
            hold_left--;
        end else begin
            i_out_stall = ($urandom_range(99) < stall_pct);
        end
    end

    // Offer one word, with a random gap first; return once it is taken
    task automatic send_word(input logic cmd, input t_key key);
        logic taken;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_command  = cmd;
        i_key_code = key;
        taken      = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !o_in_stall;
            @(negedge i_clk);
        end
    endtask

    task automatic send_code(input t_key k0, input t_key k1, input t_key k2, input t_key k3);
        send_word(CMD_KEY, k0);
        send_word(CMD_KEY, k1);
        send_word(CMD_KEY, k2);
        send_word(CMD_KEY, k3);
    endtask

    // Drop valid and wait until every expected result has come, plus latency
    task automatic settle();
        i_in_valid = 1'b0;
        while (sb.pending() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // Pick a word that mostly follows a well-formed sequence from the present mode
    task automatic send_random();
        int   r;
        t_key k;
        r = $urandom_range(99);
        k = t_key'($urandom_range(15));
        case (sb.mode)
            MODE_LOCKOUT: begin
                send_word((r < 90) ? CMD_TICK : CMD_KEY, k);
            end
            MODE_CLOSED: begin
                if (r < 40) begin
                    aim_good = ($urandom_range(99) < 65);
                    send_word(CMD_KEY, KEY_A);
                end else if (r < 62) begin
                    aim_good = ($urandom_range(99) < 70);
                    send_word(CMD_KEY, KEY_B);
                end else if (r < 78) begin
                    send_word(CMD_TICK, k);
                end else begin
                    send_word(CMD_KEY, k);
                end
            end
            MODE_UNLOCK, MODE_CURRENT: begin
                if (r < 5) begin
                    send_word(CMD_TICK, k);
                end else if (aim_good) begin
                    send_word(CMD_KEY, sb.stored_code[sb.entry_count]);
                end else begin
                    send_word(CMD_KEY, k);
                end
            end
            MODE_OPEN: begin
                if (r < 50) begin
                    send_word(CMD_KEY, KEY_C);
                end else begin
                    send_word(logic'($urandom_range(1)), k);
                end
            end
            default: begin
                send_word(logic'($urandom_range(1)), k);
            end
        endcase
    endtask

    initial begin
        int   phase;
        int   idle_tab [4];
        int   stall_tab [4];
        int   max_tab [4];
        int   ticks_tab [4];
        t_key bad;

        idle_tab  = '{0, 77, 0, 28};
        stall_tab = '{0, 0, 77, 28};
        max_tab   = '{2, 1, 15, 4};
        ticks_tab = '{5, 0, 12, 1};

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_MAX_ATTEMPTS;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_command   = CMD_KEY;
        i_key_code  = '0;
        i_out_stall = 1'b0;
        idle_pct    = 0;
        stall_pct   = 0;
        hold_left   = 0;
        cycles      = 0;
        aim_good    = 1'b1;
        sb          = new();

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Closed menu: stray tick and keys are ignored
        send_word(CMD_TICK, 4'd15);
        send_word(CMD_KEY, 4'd0);
        send_word(CMD_KEY, KEY_C);
        // Unlock with the default code, poke the open safe, close it
        send_word(CMD_KEY, KEY_A);
        send_code(4'd1, 4'd2, 4'd3, 4'd4);
        send_word(CMD_KEY, KEY_A);
        send_word(CMD_TICK, 4'd0);
        send_word(CMD_KEY, KEY_C);
        // Change the code to extreme keys, then fail a change and an unlock
        send_word(CMD_KEY, KEY_B);
        send_code(4'd1, 4'd2, 4'd3, 4'd4);
        send_code(4'd15, 4'd0, 4'd14, 4'd9);
        send_word(CMD_KEY, KEY_B);
        send_code(4'd0, 4'd0, 4'd0, 4'd0);
        send_word(CMD_KEY, KEY_A);
        send_code(4'd1, 4'd2, 4'd3, 4'd4);

        // Short lockout: keys ignored, ticks count down to the unlock
        settle();
        write_reg(CFG_MAX_ATTEMPTS, 20'd1);
        write_reg(CFG_LOCKOUT_TICKS, 20'd3);
        send_word(CMD_KEY, KEY_A);
        send_word(CMD_KEY, 4'd5);
        repeat (3) send_word(CMD_TICK, 4'd7);

        // Zero attempts and zero ticks: every request locks, one tick unlocks
        settle();
        write_reg(CFG_MAX_ATTEMPTS, 20'd0);
        write_reg(CFG_LOCKOUT_TICKS, 20'd0);
        send_word(CMD_KEY, KEY_A);
        send_word(CMD_TICK, 4'd8);
        send_word(CMD_KEY, KEY_A);
        send_word(CMD_TICK, 4'd0);

        // Run the fail count up to the largest limit, then lock and recover
        settle();
        write_reg(CFG_MAX_ATTEMPTS, 20'd15);
        write_reg(CFG_LOCKOUT_TICKS, 20'd2);
        repeat (15) begin
            bad = sb.stored_code[0] + 4'd1;
            send_word(CMD_KEY, KEY_A);
            send_code(bad, sb.stored_code[1], sb.stored_code[2], sb.stored_code[3]);
        end
        send_word(CMD_KEY, KEY_A);
        repeat (2) send_word(CMD_TICK, 4'd3);

        // Random phases with different idling and configuration
        for (phase = 0; phase < 4; phase++) begin
            settle();
            write_reg(CFG_MAX_ATTEMPTS, CFG_W'(max_tab[phase]));
            write_reg(CFG_LOCKOUT_TICKS, CFG_W'(ticks_tab[phase]));
            idle_pct  = idle_tab[phase];
            stall_pct = stall_tab[phase];
            // Hold the result side off while words keep coming
            if (phase == 0) begin
                hold_left = 60;
            end
            repeat (PHASE_WORDS) send_random();
        end

        // Longest lockout: load it and see ticks and keys ignored
        settle();
        idle_pct  = 0;
        stall_pct = 0;
        write_reg(CFG_MAX_ATTEMPTS, 20'd0);
        write_reg(CFG_LOCKOUT_TICKS, 20'hFFFFF);
        send_word(CMD_KEY, KEY_A);
        repeat (20) send_word(CMD_TICK, 4'd15);
        send_word(CMD_KEY, KEY_A);

        i_in_valid = 1'b0;
        while (sb.pending() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
